// ===== rtl/core/touch_calibration_affine_core_macros.svh =====
// Assertion helpers shared by the touch calibration core modules.
// Both expect clk_i and rst_ni in the scope of the use.
`ifndef TOUCH_CALIBRATION_AFFINE_CORE_MACROS_SVH
`define TOUCH_CALIBRATION_AFFINE_CORE_MACROS_SVH

// Property checked at every clock edge outside reset
`define TCA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next
`define TCA_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/core/tca_pkg.sv =====
package tca_pkg;

  // Field and datapath widths
  localparam int unsigned RAW_W  = 12;
  localparam int unsigned REG_W  = 32;
  localparam int unsigned POS_W  = 9;
  localparam int unsigned SPAN_W = 13;
  // |coef * raw| < 2^43, so a 44-bit magnitude holds every dividend
  localparam int unsigned MAG_W  = 44;
  localparam int unsigned QUO_W  = MAG_W + 1;
  localparam int unsigned ACC_W  = QUO_W + 2;
  localparam int unsigned CNT_W  = $clog2(MAG_W);

  // Screen spans
  localparam logic [SPAN_W-1:0] X_SPAN = SPAN_W'(480);
  localparam logic [SPAN_W-1:0] Y_SPAN = SPAN_W'(320);

  // Register map
  localparam int unsigned NUM_REGS = 7;
  localparam int unsigned IDX_W    = 3;
  typedef enum logic [IDX_W-1:0] {
    REG_DIVISOR = 3'd0,
    REG_CXX     = 3'd1,
    REG_CXY     = 3'd2,
    REG_OFFX    = 3'd3,
    REG_CYX     = 3'd4,
    REG_CYY     = 3'd5,
    REG_OFFY    = 3'd6
  } reg_idx_e;

  // Divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Clamp an accumulated coordinate to [0, span-1], keep the low bits
  function automatic logic [POS_W-1:0] clamp_pos(input logic signed [ACC_W-1:0] v,
                                                 input logic [SPAN_W-1:0] span);
    logic [SPAN_W-1:0] top_v;
    logic [POS_W-1:0]  res;
    top_v = span - SPAN_W'(1);
    if (v[ACC_W-1]) begin
      res = '0;
    end else if (v >= $signed({{(ACC_W-SPAN_W){1'b0}}, span})) begin
      res = top_v[POS_W-1:0];
    end else begin
      res = v[POS_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/tca_divider.sv =====
`include "touch_calibration_affine_core_macros.svh"

// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
// A zero divisor gives a zero quotient.
module tca_divider (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [tca_pkg::MAG_W-1:0]    num_i,
  input  logic signed [tca_pkg::REG_W-1:0]    den_i,
  output logic signed [tca_pkg::QUO_W-1:0]    quo_o,
  output tca_pkg::div_status_t                status_o
);

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_RUN  = 3'b010,
    D_FIN  = 3'b100
  } div_state_e;

  div_state_e                        state_q, state_d;
  logic [tca_pkg::CNT_W-1:0]         cnt_q;
  logic [tca_pkg::MAG_W-1:0]         mag_q;
  logic [tca_pkg::REG_W-1:0]         rem_q;
  logic [tca_pkg::REG_W-1:0]         dmag_q;
  logic                              neg_q;
  logic                              zero_q;
  logic                              done_q;
  logic signed [tca_pkg::QUO_W-1:0]  quo_q;

  logic [tca_pkg::REG_W:0]           trial;
  logic [tca_pkg::REG_W+1:0]         diff;
  logic                              fits;
  logic [tca_pkg::QUO_W-1:0]         qext;

  // One trial subtraction per cycle
  assign trial = {rem_q, mag_q[tca_pkg::MAG_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dmag_q};
  assign fits  = ~diff[tca_pkg::REG_W+1];
  assign qext  = {1'b0, mag_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      D_IDLE: begin
        if (start_i) state_d = D_RUN;
      end
      D_RUN: begin
        if (cnt_q == '0) state_d = D_FIN;
      end
      D_FIN: begin
        state_d = D_IDLE;
      end
      default: state_d = D_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == D_FIN);
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      D_IDLE: begin
        if (start_i) begin
          mag_q  <= num_i[tca_pkg::MAG_W-1] ? tca_pkg::MAG_W'(-num_i) : num_i;
          dmag_q <= den_i[tca_pkg::REG_W-1] ? tca_pkg::REG_W'(-den_i) : den_i;
          neg_q  <= num_i[tca_pkg::MAG_W-1] ^ den_i[tca_pkg::REG_W-1];
          zero_q <= (den_i == '0);
          rem_q  <= '0;
          cnt_q  <= tca_pkg::CNT_W'(tca_pkg::MAG_W - 1);
        end
      end
      D_RUN: begin
        rem_q <= fits ? diff[tca_pkg::REG_W-1:0] : trial[tca_pkg::REG_W-1:0];
        mag_q <= {mag_q[tca_pkg::MAG_W-2:0], fits};
        cnt_q <= cnt_q - tca_pkg::CNT_W'(1);
      end
      D_FIN: begin
        if (zero_q) begin
          quo_q <= '0;
        end else begin
          quo_q <= neg_q ? $signed(-qext) : $signed(qext);
        end
      end
      default: ;
    endcase
  end

  assign quo_o           = quo_q;
  assign status_o.busy   = (state_q != D_IDLE);
  assign status_o.done   = done_q;

  `TCA_ASSERT(a_done_idle, !(status_o.done && status_o.busy), "divider done while busy")
  `TCA_ASSERT_NEXT(a_done_pulse, status_o.done, !status_o.done, "divider done longer than one cycle")
  `TCA_ASSERT_NEXT(a_start_runs, start_i && !status_o.busy, state_q == D_RUN, "divider start not taken")

endmodule

// ===== rtl/core/touch_calibration_affine_core.sv =====
// Sequence: a pressed item runs six terms in turn (each a multiply, a divider start,
// 44 quotient bits, finish); a released item goes straight to the output stage.
// Throughput: one item at a time; the shared 44-step divider sets the rate.
// Reset: registers return to divisor 1, identity matrix, zero offsets; held point is (0, 0).
`include "touch_calibration_affine_core_macros.svh"

module touch_calibration_affine_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [tca_pkg::IDX_W-1:0]         cfg_idx_i,
  input  logic [tca_pkg::REG_W-1:0]         cfg_wdata_i,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              touched_i,
  input  logic [tca_pkg::RAW_W-1:0]         raw_x_i,
  input  logic [tca_pkg::RAW_W-1:0]         raw_y_i,
  // output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              press_state_o,
  output logic [tca_pkg::POS_W-1:0]         pos_x_o,
  output logic [tca_pkg::POS_W-1:0]         pos_y_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_MUL    = 6'b000010,
    S_DSTART = 6'b000100,
    S_DWAIT  = 6'b001000,
    S_OUT    = 6'b010000,
    S_SPARE  = 6'b100000
  } seq_state_e;

  typedef enum logic [2:0] {
    T_XX = 3'd0,
    T_XY = 3'd1,
    T_XO = 3'd2,
    T_YX = 3'd3,
    T_YY = 3'd4,
    T_YO = 3'd5
  } term_e;

  seq_state_e                         state_q;
  term_e                              term_q;
  logic [tca_pkg::REG_W-1:0]          cfg_q [tca_pkg::NUM_REGS];
  logic [tca_pkg::RAW_W-1:0]          rx_q, ry_q;
  logic                               press_q;
  logic signed [tca_pkg::MAG_W-1:0]   num_q, num_d;
  logic signed [tca_pkg::ACC_W-1:0]   acc_x_q, acc_y_q;
  logic [tca_pkg::POS_W-1:0]          held_x_q, held_y_q;
  logic [tca_pkg::POS_W-1:0]          clamp_x, clamp_y;
  logic                               out_valid_q, out_press_q;
  logic [tca_pkg::POS_W-1:0]          out_x_q, out_y_q;
  logic                               in_acc, out_load, div_start;
  logic signed [tca_pkg::REG_W-1:0]   coef;
  logic [tca_pkg::RAW_W-1:0]          raw_sel;
  logic                               is_offset;
  logic signed [tca_pkg::MAG_W:0]     prod;
  logic signed [tca_pkg::QUO_W-1:0]   quo;
  logic signed [tca_pkg::ACC_W-1:0]   quo_ext;
  tca_pkg::div_status_t               div_st;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);
  assign div_start  = (state_q == S_DSTART);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[tca_pkg::REG_DIVISOR] <= tca_pkg::REG_W'(1);
      cfg_q[tca_pkg::REG_CXX]     <= tca_pkg::REG_W'(1);
      cfg_q[tca_pkg::REG_CXY]     <= '0;
      cfg_q[tca_pkg::REG_OFFX]    <= '0;
      cfg_q[tca_pkg::REG_CYX]     <= '0;
      cfg_q[tca_pkg::REG_CYY]     <= tca_pkg::REG_W'(1);
      cfg_q[tca_pkg::REG_OFFY]    <= '0;
    end else if (cfg_we_i && (32'(cfg_idx_i) < tca_pkg::NUM_REGS)) begin
      cfg_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // Operand selection for the current term
  always_comb begin
    coef      = '0;
    raw_sel   = rx_q;
    is_offset = 1'b0;
    unique case (term_q)
      T_XX: coef = $signed(cfg_q[tca_pkg::REG_CXX]);
      T_XY: begin
        coef    = $signed(cfg_q[tca_pkg::REG_CXY]);
        raw_sel = ry_q;
      end
      T_XO: begin
        coef      = $signed(cfg_q[tca_pkg::REG_OFFX]);
        is_offset = 1'b1;
      end
      T_YX: coef = $signed(cfg_q[tca_pkg::REG_CYX]);
      T_YY: begin
        coef    = $signed(cfg_q[tca_pkg::REG_CYY]);
        raw_sel = ry_q;
      end
      T_YO: begin
        coef      = $signed(cfg_q[tca_pkg::REG_OFFY]);
        is_offset = 1'b1;
      end
      default: ;
    endcase
  end

  // Exact 32 x 12 product, or the sign-extended offset
  assign prod  = coef * $signed({1'b0, raw_sel});
  assign num_d = is_offset ? tca_pkg::MAG_W'(coef) : prod[tca_pkg::MAG_W-1:0];

  tca_divider u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (num_q),
    .den_i    ($signed(cfg_q[tca_pkg::REG_DIVISOR])),
    .quo_o    (quo),
    .status_o (div_st)
  );

  assign quo_ext = tca_pkg::ACC_W'(quo);
  assign clamp_x = tca_pkg::clamp_pos(acc_x_q, tca_pkg::X_SPAN);
  assign clamp_y = tca_pkg::clamp_pos(acc_y_q, tca_pkg::Y_SPAN);

  // Sequencer and held point
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      term_q   <= T_XX;
      held_x_q <= '0;
      held_y_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            term_q  <= T_XX;
            state_q <= touched_i ? S_MUL : S_OUT;
          end
        end
        S_MUL:    state_q <= S_DSTART;
        S_DSTART: state_q <= S_DWAIT;
        S_DWAIT: begin
          if (div_st.done) begin
            if (term_q == T_YO) begin
              state_q <= S_OUT;
            end else begin
              term_q  <= term_e'(term_q + 3'd1);
              state_q <= S_MUL;
            end
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_q <= S_IDLE;
            if (press_q) begin
              held_x_q <= clamp_x;
              held_y_q <= clamp_y;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Item payload and accumulators
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      press_q <= touched_i;
      rx_q    <= raw_x_i;
      ry_q    <= raw_y_i;
      acc_x_q <= '0;
      acc_y_q <= '0;
    end
    if (state_q == S_MUL) begin
      num_q <= num_d;
    end
    if ((state_q == S_DWAIT) && div_st.done) begin
      if (term_q == T_XX || term_q == T_XY || term_q == T_XO) begin
        acc_x_q <= acc_x_q + quo_ext;
      end else begin
        acc_y_q <= acc_y_q + quo_ext;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_press_q <= press_q;
      out_x_q     <= press_q ? clamp_x : held_x_q;
      out_y_q     <= press_q ? clamp_y : held_y_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign press_state_o = out_press_q;
  assign pos_x_o       = out_x_q;
  assign pos_y_o       = out_y_q;

  `TCA_ASSERT(a_done_in_wait, !div_st.done || state_q == S_DWAIT, "divider done outside wait")
  `TCA_ASSERT(a_start_free, !div_start || !div_st.busy, "divider started while busy")
  `TCA_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "stalled result dropped")

endmodule

// ===== test/touch_calibration_affine_core_test.sv =====
`timescale 1ns / 100ps

module touch_calibration_affine_core_test;

  localparam int unsigned NUM_PHASES      = 16;
  localparam int unsigned ITEMS_PER_PHASE = 116;
  localparam int unsigned HOLD_OFF_PHASE  = 5;
  localparam int unsigned HOLD_OFF_CYCLES = 800;
  localparam int unsigned SETTLE_CYCLES   = 2;
  localparam int unsigned TAIL_CYCLES     = 300;
  localparam int unsigned MAX_PRINTED     = 40;
  localparam longint      X_SPAN_L        = longint'(tca_pkg::X_SPAN);
  localparam longint      Y_SPAN_L        = longint'(tca_pkg::Y_SPAN);

  // index past the register map; writes to it must be dropped
  localparam logic [tca_pkg::IDX_W-1:0] REG_UNMAPPED = tca_pkg::IDX_W'(tca_pkg::NUM_REGS);

  localparam logic [tca_pkg::REG_W-1:0] LIMIT_VALUES [6] = '{
    32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
    32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_1000
  };

  typedef struct packed {
    logic                      press;
    logic [tca_pkg::POS_W-1:0] x;
    logic [tca_pkg::POS_W-1:0] y;
  } touch_point_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e                 kind;
    logic [tca_pkg::IDX_W-1:0] idx;
    logic [tca_pkg::REG_W-1:0] data;
    logic                      touched;
    logic [tca_pkg::RAW_W-1:0] raw_x;
    logic [tca_pkg::RAW_W-1:0] raw_y;
    logic                      pinned;
    touch_point_t              want;
  } step_row_t;

  typedef enum logic [1:0] {STYLE_PANEL, STYLE_RANDOM, STYLE_LIMITS} setting_style_e;

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      cfg_we_i      = 1'b0;
  logic [tca_pkg::IDX_W-1:0] cfg_idx_i     = '0;
  logic [tca_pkg::REG_W-1:0] cfg_wdata_i   = '0;
  logic                      in_valid_i    = 1'b0;
  logic                      in_stall_o;
  logic                      touched_i     = 1'b0;
  logic [tca_pkg::RAW_W-1:0] raw_x_i       = '0;
  logic [tca_pkg::RAW_W-1:0] raw_y_i       = '0;
  logic                      out_valid_o;
  logic                      out_stall_i   = 1'b0;
  logic                      press_state_o;
  logic [tca_pkg::POS_W-1:0] pos_x_o;
  logic [tca_pkg::POS_W-1:0] pos_y_o;

  // calibration state as the block should hold it
  logic [tca_pkg::REG_W-1:0] cal_reg [tca_pkg::NUM_REGS];
  logic [tca_pkg::POS_W-1:0] held_x;
  logic [tca_pkg::POS_W-1:0] held_y;

  touch_point_t expected_points [$];
  step_row_t    directed_steps [$];

  bit          quiet_mode   = 1'b0;
  bit          hold_off_req = 1'b0;
  int unsigned errors       = 0;
  int unsigned n_checked    = 0;
  int unsigned n_pressed    = 0;
  int unsigned n_released   = 0;
  int unsigned n_clamped    = 0;
  int unsigned n_settings   = 0;

  touch_calibration_affine_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .touched_i     (touched_i),
    .raw_x_i       (raw_x_i),
    .raw_y_i       (raw_y_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .press_state_o (press_state_o),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint reg_value(input tca_pkg::reg_idx_e i);
    return longint'($signed(cal_reg[i]));
  endfunction

  // each term is divided on its own, truncating toward zero
  function automatic longint scaled_term(input longint num, input longint den);
    if (den == 0) return 0;
    return num / den;
  endfunction

  function automatic logic [tca_pkg::POS_W-1:0] clamp_coord(input longint v,
                                                           input longint span);
    if (v < 0) return '0;
    if (v >= span) return tca_pkg::POS_W'(span - 1);
    return tca_pkg::POS_W'(v);
  endfunction

  function automatic touch_point_t calibrate_sample(input logic t,
                                                    input logic [tca_pkg::RAW_W-1:0] rx,
                                                    input logic [tca_pkg::RAW_W-1:0] ry);
    longint d, ux, uy, sx, sy;
    touch_point_t p;
    if (t) begin
      ux = longint'(rx);
      uy = longint'(ry);
      d  = reg_value(tca_pkg::REG_DIVISOR);
      sx = scaled_term(reg_value(tca_pkg::REG_CXX) * ux, d)
         + scaled_term(reg_value(tca_pkg::REG_CXY) * uy, d)
         + scaled_term(reg_value(tca_pkg::REG_OFFX), d);
      sy = scaled_term(reg_value(tca_pkg::REG_CYX) * ux, d)
         + scaled_term(reg_value(tca_pkg::REG_CYY) * uy, d)
         + scaled_term(reg_value(tca_pkg::REG_OFFY), d);
      if (sx < 0 || sx >= X_SPAN_L || sy < 0 || sy >= Y_SPAN_L) n_clamped++;
      held_x = clamp_coord(sx, X_SPAN_L);
      held_y = clamp_coord(sy, Y_SPAN_L);
    end
    p.press = t;
    p.x     = held_x;
    p.y     = held_y;
    return p;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MAX_PRINTED) $display("%0t: mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  // results are compared in order against the oldest prediction
  always @(posedge clk_i) begin
    touch_point_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_points.size() == 0) begin
        report_mismatch($sformatf("result with no item pending (press %0b x %0d y %0d)",
                                  press_state_o, pos_x_o, pos_y_o));
      end else begin
        want = expected_points.pop_front();
        n_checked++;
        check_field("press_state", 16'(press_state_o), 16'(want.press));
        check_field("pos_x", 16'(pos_x_o), 16'(want.x));
        check_field("pos_y", 16'(pos_y_o), 16'(want.y));
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // random stalls, plus one long hold-off on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
        stall_left   = 0;
        out_stall_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        stall_left = pick_gap();
        out_stall_i <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // ---------------------------------------------------------------- sender

  // hold the item until taken, then predict and idle for a random gap, possibly none
  task automatic send_sample(input logic t, input logic [tca_pkg::RAW_W-1:0] rx,
                             input logic [tca_pkg::RAW_W-1:0] ry, input logic pinned,
                             input touch_point_t want);
    touch_point_t p;
    int unsigned gap;
    in_valid_i <= 1'b1;
    touched_i  <= t;
    raw_x_i    <= rx;
    raw_y_i    <= ry;
    do @(posedge clk_i); while (in_stall_o);
    p = calibrate_sample(t, rx, ry);
    expected_points.push_back(pinned ? want : p);
    if (t) n_pressed++;
    else n_released++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // caller lowers cfg_we_i after the last write of a burst
  task automatic cfg_write(input logic [tca_pkg::IDX_W-1:0] idx,
                           input logic [tca_pkg::REG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    if (idx < tca_pkg::NUM_REGS) cal_reg[idx] = value;
  endtask

  task automatic load_setting(input setting_style_e style);
    logic [tca_pkg::REG_W-1:0] vals [tca_pkg::NUM_REGS];
    int d, cxx, cxy, offx, cyx, cyy, offy;
    int unsigned stray;
    case (style)
      STYLE_PANEL: begin
        // plausible panel: scale 4096 raw counts onto the screen, small skew
        d    = $urandom_range(64, 65536);
        cxx  = 480 * d / 4096 + int'($urandom_range(0, d / 64)) - d / 128;
        cxy  = int'($urandom_range(0, d / 32)) - d / 64;
        offx = int'($urandom_range(0, 40 * d)) - 20 * d;
        cyy  = 320 * d / 4096 + int'($urandom_range(0, d / 64)) - d / 128;
        cyx  = int'($urandom_range(0, d / 32)) - d / 64;
        offy = int'($urandom_range(0, 40 * d)) - 20 * d;
        // mirrored axes
        if ($urandom_range(0, 1)) begin
          cxx  = -cxx;
          offx = offx + 480 * d;
        end
        if ($urandom_range(0, 1)) begin
          cyy  = -cyy;
          offy = offy + 320 * d;
        end
        // same map with every sign flipped
        if ($urandom_range(0, 3) == 0) begin
          d = -d; cxx = -cxx; cxy = -cxy; offx = -offx;
          cyx = -cyx; cyy = -cyy; offy = -offy;
        end
        vals[tca_pkg::REG_DIVISOR] = d;
        vals[tca_pkg::REG_CXX]     = cxx;
        vals[tca_pkg::REG_CXY]     = cxy;
        vals[tca_pkg::REG_OFFX]    = offx;
        vals[tca_pkg::REG_CYX]     = cyx;
        vals[tca_pkg::REG_CYY]     = cyy;
        vals[tca_pkg::REG_OFFY]    = offy;
      end
      STYLE_RANDOM: begin
        foreach (vals[i]) vals[i] = $urandom();
      end
      default: begin
        foreach (vals[i]) vals[i] = LIMIT_VALUES[$urandom_range(0, 5)];
      end
    endcase
    stray = $urandom_range(0, tca_pkg::NUM_REGS);
    for (int i = 0; i < tca_pkg::NUM_REGS; i++) begin
      if (i == stray) cfg_write(REG_UNMAPPED, $urandom());
      cfg_write(tca_pkg::IDX_W'(i), vals[i]);
    end
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [tca_pkg::RAW_W-1:0] pick_raw();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return tca_pkg::RAW_W'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic step_row_t write_row(input logic [tca_pkg::IDX_W-1:0] idx,
                                          input logic [tca_pkg::REG_W-1:0] data);
    step_row_t r;
    r      = '0;
    r.kind = ROW_WRITE;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  function automatic step_row_t sample_row(input logic t, input int rx, input int ry);
    step_row_t r;
    r         = '0;
    r.kind    = ROW_SAMPLE;
    r.touched = t;
    r.raw_x   = tca_pkg::RAW_W'(rx);
    r.raw_y   = tca_pkg::RAW_W'(ry);
    return r;
  endfunction

  function automatic step_row_t pinned_row(input logic t, input int rx, input int ry,
                                           input logic press, input int x, input int y);
    step_row_t r;
    r            = sample_row(t, rx, ry);
    r.pinned     = 1'b1;
    r.want.press = press;
    r.want.x     = tca_pkg::POS_W'(x);
    r.want.y     = tca_pkg::POS_W'(y);
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  initial begin
    bit writing;
    setting_style_e style;
    logic t;
    writing = 1'b0;

    // reset values: divisor 1, identity matrix, zero offsets, held point at origin
    foreach (cal_reg[i]) cal_reg[i] = '0;
    cal_reg[tca_pkg::REG_DIVISOR] = 1;
    cal_reg[tca_pkg::REG_CXX]     = 1;
    cal_reg[tca_pkg::REG_CYY]     = 1;
    held_x = '0;
    held_y = '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_steps = '{
      // identity map after reset, held point starts at origin
      pinned_row(1'b0, 4095, 4095, 1'b0, 0, 0),
      pinned_row(1'b1, 0, 0, 1'b1, 0, 0),
      pinned_row(1'b1, 4095, 4095, 1'b1, 479, 319),
      pinned_row(1'b1, 100, 200, 1'b1, 100, 200),
      // released: raw ignored, last point held
      pinned_row(1'b0, 12'hABC, 12'h123, 1'b0, 100, 200),
      pinned_row(1'b1, 479, 319, 1'b1, 479, 319),
      pinned_row(1'b1, 480, 320, 1'b1, 479, 319),
      // write past the map is dropped
      write_row(REG_UNMAPPED, 32'h0000_0000),
      pinned_row(1'b1, 5, 6, 1'b1, 5, 6),
      // zero divisor sends the point to the origin
      write_row(tca_pkg::REG_DIVISOR, 32'h0000_0000),
      pinned_row(1'b1, 4095, 4095, 1'b1, 0, 0),
      pinned_row(1'b0, 7, 7, 1'b0, 0, 0),
      // divisor -1: negative terms clamp low, most negative offset clamps high
      write_row(tca_pkg::REG_DIVISOR, 32'hFFFF_FFFF),
      pinned_row(1'b1, 300, 300, 1'b1, 0, 0),
      write_row(tca_pkg::REG_OFFX, 32'h8000_0000),
      write_row(tca_pkg::REG_OFFY, 32'h7FFF_FFFF),
      pinned_row(1'b1, 300, 300, 1'b1, 479, 0),
      // full-width products at the register extremes
      write_row(tca_pkg::REG_DIVISOR, 32'h7FFF_FFFF),
      write_row(tca_pkg::REG_CXX, 32'h7FFF_FFFF),
      write_row(tca_pkg::REG_CXY, 32'h8000_0000),
      sample_row(1'b1, 4095, 0),
      sample_row(1'b1, 4095, 4095),
      write_row(tca_pkg::REG_DIVISOR, 32'h8000_0000),
      write_row(tca_pkg::REG_CYX, 32'h8000_0000),
      write_row(tca_pkg::REG_CYY, 32'h7FFF_FFFF),
      sample_row(1'b1, 4095, 4095),
      // truncation toward zero on negative terms
      write_row(tca_pkg::REG_DIVISOR, 32'd3),
      write_row(tca_pkg::REG_CXX, 32'hFFFF_FFFF),
      write_row(tca_pkg::REG_CXY, 32'd0),
      write_row(tca_pkg::REG_OFFX, 32'd1000),
      write_row(tca_pkg::REG_CYX, 32'd0),
      write_row(tca_pkg::REG_CYY, 32'd2),
      write_row(tca_pkg::REG_OFFY, 32'hFFFF_F000),
      sample_row(1'b1, 4, 4),
      sample_row(1'b1, 5, 1000),
      // plain screen scaling
      write_row(tca_pkg::REG_DIVISOR, 32'd4096),
      write_row(tca_pkg::REG_CXX, 32'd480),
      write_row(tca_pkg::REG_CXY, 32'd0),
      write_row(tca_pkg::REG_OFFX, 32'd0),
      write_row(tca_pkg::REG_CYX, 32'd0),
      write_row(tca_pkg::REG_CYY, 32'd320),
      write_row(tca_pkg::REG_OFFY, 32'd0),
      sample_row(1'b1, 2048, 2048),
      sample_row(1'b1, 4095, 0),
      sample_row(1'b0, 0, 0)
    };

    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == ROW_WRITE) begin
        if (!writing) begin
          wait_drained();
          writing = 1'b1;
        end
        cfg_write(directed_steps[i].idx, directed_steps[i].data);
      end else begin
        if (writing) begin
          cfg_we_i <= 1'b0;
          writing = 1'b0;
          n_settings++;
        end
        send_sample(directed_steps[i].touched, directed_steps[i].raw_x,
                    directed_steps[i].raw_y, directed_steps[i].pinned,
                    directed_steps[i].want);
      end
    end

    // random phases, each under a fresh register setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      quiet_mode = ($urandom_range(0, 3) == 0);
      case (ph % 4)
        2:       style = STYLE_RANDOM;
        3:       style = STYLE_LIMITS;
        default: style = STYLE_PANEL;
      endcase
      load_setting(style);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // receiver blocks for a long stretch while items keep coming
        if (ph == HOLD_OFF_PHASE && k == 40) hold_off_req = 1'b1;
        t = ($urandom_range(0, 99) < 70);
        send_sample(t, pick_raw(), pick_raw(), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d samples (%0d pressed, %0d released) under %0d register settings",
             n_pressed + n_released, n_pressed, n_released, n_settings);
    $display("checked %0d results, %0d pressed points clamped at the screen border",
             n_checked, n_clamped);
    if (errors == 0 && expected_points.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
